// File: rtl/ttw_pkg.sv
// Shared types, constants and command codes of the text terminal writer.
`default_nettype none

package ttw_pkg;

  // Screen geometry. The item fields have fixed widths, so the geometry is fixed too.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int CELL_W  = ATTR_W + CHAR_W;

  // Character codes with a meaning of their own.
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0] RETURN_CHAR  = 8'h0D;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_CELL   = {RESET_ATTR, BLANK_CHAR};

  // Operation codes of an input item.
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Default queue depths.
  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 2;

  typedef enum logic [2:0] {
    CMD_PRINT,
    CMD_NEWLINE,
    CMD_RETURN,
    CMD_IGNORE,
    CMD_READ
  } cmd_kind_t;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_RUN,
    ST_READ
  } back_state_t;

  typedef struct packed {
    logic              operation;
    logic [CHAR_W-1:0] character;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_column;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] read_cell;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_column;
    logic              scrolled;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CHAR_W-1:0] character;
    logic              in_range;
    logic [ADDR_W-1:0] row_offset;
    logic [COL_W-1:0]  column;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/ttw_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module ttw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

// File: rtl/ttw_fifo.sv
// Small register queue used between the front, the back and the result port.
`default_nettype none

module ttw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ttw_front.sv
// Front end: decodes each input beat into a terminal command for the back end.
`default_nettype none

module ttw_front (
  input  wire logic              push,
  input  wire logic              full,
  input  wire ttw_pkg::in_item_t in_item,
  output logic                   cmd_push,
  output ttw_pkg::cmd_t          cmd
);

  assign cmd_push = push && !full;

  always_comb begin
    cmd.character = in_item.character;
    cmd.column    = in_item.read_column;
    cmd.in_range  = (in_item.read_row < ttw_pkg::ROW_W'(ttw_pkg::ROWS)) &&
                    (in_item.read_column < ttw_pkg::COL_W'(ttw_pkg::COLUMNS));
    // The row offset is only meaningful for a cell on the screen.
    cmd.row_offset = cmd.in_range ?
                     ttw_pkg::ADDR_W'(in_item.read_row) *
                     ttw_pkg::ADDR_W'(ttw_pkg::COLUMNS) : '0;
    priority if (in_item.operation == ttw_pkg::OP_READ) begin
      cmd.kind = ttw_pkg::CMD_READ;
    end else if (in_item.character >= ttw_pkg::BLANK_CHAR) begin
      cmd.kind = ttw_pkg::CMD_PRINT;
    end else if (in_item.character == ttw_pkg::NEWLINE_CHAR) begin
      cmd.kind = ttw_pkg::CMD_NEWLINE;
    end else if (in_item.character == ttw_pkg::RETURN_CHAR) begin
      cmd.kind = ttw_pkg::CMD_RETURN;
    end else begin
      cmd.kind = ttw_pkg::CMD_IGNORE;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ttw_back.sv
// Back end: cursor, screen memory with a rotating top row, and the fill sequencer.
`default_nettype none

module ttw_back (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic      [ttw_pkg::ATTR_W-1:0]  cfg_data,
  input  wire ttw_pkg::cmd_t                    cmd,
  input  wire logic                             cmd_empty,
  output logic                                  cmd_pop,
  output ttw_pkg::out_item_t                    res,
  output logic                                  res_push,
  input  wire logic                             res_full,
  output logic                                  clearing
);

  localparam int AW = ttw_pkg::ADDR_W;

  ttw_pkg::back_state_t state_r, state_nxt;
  logic [ttw_pkg::ATTR_W-1:0] attr_r;
  logic [ttw_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [ttw_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [AW-1:0]              cur_base_r, cur_base_nxt;
  logic [AW-1:0]              top_base_r, top_base_nxt;
  logic [AW-1:0]              fill_addr_r, fill_addr_nxt;
  logic [AW-1:0]              fill_last_r, fill_last_nxt;
  logic [ttw_pkg::CELL_W-1:0] fill_data_r, fill_data_nxt;
  logic                       clearing_r, clearing_nxt;

  logic                       ram_we;
  logic [AW-1:0]              ram_wr_addr;
  logic [ttw_pkg::CELL_W-1:0] ram_wr_data;
  logic [AW-1:0]              ram_rd_addr;
  logic [ttw_pkg::CELL_W-1:0] ram_rd_data;
  logic [AW:0]                rd_sum;
  logic [AW:0]                rd_wrapped;
  logic                       do_nl;
  logic                       scrolled;

  // Row bases are multiples of COLUMNS, so the step past the last row lands on zero.
  function automatic logic [AW-1:0] next_base(input logic [AW-1:0] base);
    next_base = (base == AW'(ttw_pkg::CELLS - ttw_pkg::COLUMNS)) ?
                '0 : base + AW'(ttw_pkg::COLUMNS);
  endfunction

  assign clearing = clearing_r;
  assign cmd_pop  = (state_r == ttw_pkg::ST_RUN) && !cmd_empty && !res_full;

  // Read address: logical row offset rotated by the top row base.
  assign rd_sum      = {1'b0, cmd.row_offset} + {1'b0, top_base_r};
  assign rd_wrapped  = (rd_sum >= (AW + 1)'(ttw_pkg::CELLS)) ?
                       rd_sum - (AW + 1)'(ttw_pkg::CELLS) : rd_sum;
  assign ram_rd_addr = rd_wrapped[AW-1:0] + AW'(cmd.column);

  ttw_ram #(
    .WIDTH (ttw_pkg::CELL_W),
    .DEPTH (ttw_pkg::CELLS)
  ) u_screen (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    cur_base_nxt  = cur_base_r;
    top_base_nxt  = top_base_r;
    fill_addr_nxt = fill_addr_r;
    fill_last_nxt = fill_last_r;
    fill_data_nxt = fill_data_r;
    clearing_nxt  = clearing_r;
    ram_we        = 1'b0;
    ram_wr_addr   = cur_base_r + AW'(col_r);
    ram_wr_data   = {attr_r, cmd.character};
    res_push      = 1'b0;
    res           = '0;
    do_nl         = 1'b0;
    scrolled      = 1'b0;

    unique case (state_r)
      ttw_pkg::ST_FILL: begin
        ram_we      = 1'b1;
        ram_wr_addr = fill_addr_r;
        ram_wr_data = fill_data_r;
        if (fill_addr_r == fill_last_r) begin
          state_nxt    = ttw_pkg::ST_RUN;
          clearing_nxt = 1'b0;
        end else begin
          fill_addr_nxt = fill_addr_r + 1'b1;
        end
      end
      ttw_pkg::ST_RUN: begin
        if (cmd_pop) begin
          unique case (cmd.kind)
            ttw_pkg::CMD_PRINT: begin
              ram_we = 1'b1;
              if (col_r == ttw_pkg::COL_W'(ttw_pkg::COLUMNS - 1)) begin
                do_nl = 1'b1;
              end else begin
                col_nxt = col_r + 1'b1;
              end
            end
            ttw_pkg::CMD_NEWLINE: begin
              do_nl = 1'b1;
            end
            ttw_pkg::CMD_RETURN: begin
              col_nxt = '0;
            end
            ttw_pkg::CMD_IGNORE: begin
            end
            ttw_pkg::CMD_READ: begin
              if (cmd.in_range) begin
                state_nxt = ttw_pkg::ST_READ;
              end
            end
            default: begin
            end
          endcase

          if (do_nl) begin
            col_nxt = '0;
            if (row_r == ttw_pkg::ROW_W'(ttw_pkg::ROWS - 1)) begin
              // Scroll: the old top row becomes the new bottom row and is blanked.
              scrolled      = 1'b1;
              cur_base_nxt  = top_base_r;
              top_base_nxt  = next_base(top_base_r);
              fill_addr_nxt = top_base_r;
              fill_last_nxt = top_base_r + AW'(ttw_pkg::COLUMNS - 1);
              fill_data_nxt = {attr_r, ttw_pkg::BLANK_CHAR};
              state_nxt     = ttw_pkg::ST_FILL;
            end else begin
              row_nxt      = row_r + 1'b1;
              cur_base_nxt = next_base(cur_base_r);
            end
          end

          if (!(cmd.kind == ttw_pkg::CMD_READ && cmd.in_range)) begin
            res_push          = 1'b1;
            res.read_cell     = '0;
            res.cursor_row    = row_nxt;
            res.cursor_column = col_nxt;
            res.scrolled      = scrolled;
          end
        end
      end
      ttw_pkg::ST_READ: begin
        res_push          = 1'b1;
        res.read_cell     = ram_rd_data;
        res.cursor_row    = row_r;
        res.cursor_column = col_r;
        res.scrolled      = 1'b0;
        state_nxt         = ttw_pkg::ST_RUN;
      end
      default: begin
        state_nxt = ttw_pkg::ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ttw_pkg::ST_FILL;
      clearing_r  <= 1'b1;
      attr_r      <= ttw_pkg::RESET_ATTR;
      row_r       <= '0;
      col_r       <= '0;
      cur_base_r  <= '0;
      top_base_r  <= '0;
      fill_addr_r <= '0;
      fill_last_r <= AW'(ttw_pkg::CELLS - 1);
      fill_data_r <= ttw_pkg::BLANK_CELL;
    end else begin
      state_r     <= state_nxt;
      clearing_r  <= clearing_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      cur_base_r  <= cur_base_nxt;
      top_base_r  <= top_base_nxt;
      fill_addr_r <= fill_addr_nxt;
      fill_last_r <= fill_last_nxt;
      fill_data_r <= fill_data_nxt;
      if (cfg_we) begin
        attr_r <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/text_terminal_writer_unit.sv
// Top level of the text terminal writer: front end, command queue, back end, result queue.
//
// Usage. The input side is a queue: drive in_item and raise push; the beat is
// taken at a rising edge where push is high and full is low. Each beat either
// puts a character (printable, newline, carriage return or ignored control
// byte) or reads one screen cell. Every beat yields exactly one result beat,
// offered on out_item while empty is low and taken at an edge with pop high.
// cfg_we/cfg_data write the text attribute; write it only while the block
// is idle.
// Timing. A beat goes into a short command queue at acceptance; the back end
// takes it when running with room in the result queue. Puts and control bytes
// finish in the cycle the back end takes them and show on the result side in
// the cycle after. A read of a cell on the screen passes through the read
// state for the registered screen memory read port, which holds off the next
// beat. Sustained rate: one put per cycle while no scroll, read or full result
// queue holds the back end. A scroll rotates the top row pointer and then
// blanks one row through the memory write port; beats still queue meanwhile.
// Reset: a clearing pass writes every cell blank in attribute 7, one cell per
// cycle, with full held high. When the receiver stalls, the result queue
// fills, the back end stops, and then the command queue fills and raises full.
`default_nettype none

module text_terminal_writer_unit #(
  parameter int CMD_DEPTH = ttw_pkg::CMD_DEPTH,
  parameter int RES_DEPTH = ttw_pkg::RES_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            push,
  output logic                                 full,
  input  wire ttw_pkg::in_item_t               in_item,
  output logic                                 empty,
  input  wire logic                            pop,
  output ttw_pkg::out_item_t                   out_item,
  input  wire logic                            cfg_we,
  input  wire logic     [ttw_pkg::ATTR_W-1:0]  cfg_data
);

  // Decoded command between front and back.
  ttw_pkg::cmd_t      cmd_in;
  ttw_pkg::cmd_t      cmd_out;
  logic               cmd_push;
  logic               cmd_full;
  logic               cmd_empty;
  logic               cmd_pop;

  // Result beat from the back end into the result queue.
  ttw_pkg::out_item_t res;
  logic               res_push;
  logic               res_full;
  logic               clearing;

  // The block takes no beat while the screen is being cleared after reset.
  assign full = cmd_full || clearing;

  ttw_front u_front (
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  ttw_fifo #(
    .WIDTH ($bits(ttw_pkg::cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  ttw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res       (res),
    .res_push  (res_push),
    .res_full  (res_full),
    .clearing  (clearing)
  );

  // The result queue decouples the back end from a stalling receiver.
  ttw_fifo #(
    .WIDTH ($bits(ttw_pkg::out_item_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res),
    .full    (res_full),
    .pop     (pop),
    .rd_data (out_item),
    .empty   (empty)
  );

`ifndef ASSERT_OFF
  // The back end must never hand a result to a full result queue.
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result beat pushed into a full result queue");

  // After reset the input side is closed for the clearing pass.
  a_reset_closes_input: assert property (@(posedge clk)
    !rst_n |=> full)
    else $error("input open right after reset");

  // A scroll always leaves the cursor at the start of the last row.
  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.scrolled) |->
      (out_item.cursor_row == ttw_pkg::ROW_W'(ttw_pkg::ROWS - 1) &&
       out_item.cursor_column == '0))
    else $error("scroll result with cursor off the last row start");

  // The reported cursor stays on the screen.
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_item.cursor_column < ttw_pkg::COL_W'(ttw_pkg::COLUMNS) &&
                out_item.cursor_row < ttw_pkg::ROW_W'(ttw_pkg::ROWS)))
    else $error("cursor reported outside the screen");
`endif

endmodule

`default_nettype wire
